// ===== hdl/ddm_pkg.sv =====
// Shared package for the depth discontinuity mask.
// Holds the widths, register index codes and struct types that the front end,
// the grid point queue, the back end and the top level all use.
package ddm_pkg;

   // depth samples and threshold arithmetic
   localparam int DEPTH_W  = 16;                  // depth in millimetres
   localparam int FRAC_W   = 16;                  // fraction bits of the Q0.16 threshold
   localparam int REL_W    = 16;                  // rel_threshold register
   localparam int STEP_W   = 4;                   // grid_step register
   localparam int RS_W     = REL_W + STEP_W;      // rel_threshold * grid_step
   localparam int THR_W    = RS_W + DEPTH_W;      // full threshold product
   localparam int PAIR_W   = 2 * DEPTH_W;         // upper and middle row sample together

   // frame geometry
   localparam int SIZE_W   = 13;                  // frame_width / frame_height registers
   localparam int SIZE_MAX = 4096;                // largest usable frame size
   localparam int POS_W    = 12;                  // pixel and grid position counters

   // line store
   localparam int GRID_COLS = 4096;
   localparam int GRID_AW   = $clog2(GRID_COLS);

   // queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 16;

   // stream words
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_FIELD_W = 2 * POS_W + 1;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   // window size (3x3 grid neighbourhood)
   localparam int WIN_N      = 9;
   localparam int WIN_CENTRE = 4;

   typedef enum logic [CSR_AW-1:0] {
      CSR_FRAME_WIDTH   = 3'd0,
      CSR_FRAME_HEIGHT  = 3'd1,
      CSR_GRID_STEP     = 3'd2,
      CSR_REL_THRESHOLD = 3'd3,
      CSR_DEPTH_LO      = 3'd4,
      CSR_DEPTH_HI      = 3'd5
   } csr_index_type;

   // geometry settings used by the front end (already clamped)
   typedef struct packed {
      logic [SIZE_W-1:0] frame_width;
      logic [SIZE_W-1:0] frame_height;
      logic [STEP_W-1:0] grid_step;
   } geom_cfg_type;

   // check settings used by the back end
   typedef struct packed {
      logic [RS_W-1:0]    rel_step;
      logic [DEPTH_W-1:0] depth_lo;
      logic [DEPTH_W-1:0] depth_hi;
   } check_cfg_type;

   // one grid point handed from front to back end
   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic [GRID_AW-1:0] grid_col;
      logic [POS_W-1:0]   cell_row;
      logic [POS_W-1:0]   cell_col;
      logic               emit;
      logic               last;
   } grid_item_type;

endpackage

// ===== hdl/ddm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// A read at the address written in the same cycle returns the old contents.
// No dependencies.
module ddm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ddm_front.sv =====
// Front end: takes depth words, tracks pixel and grid position, and passes
// grid points to the queue. Non-grid pixels are consumed here.
// Depends on ddm_pkg.
module ddm_front import ddm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  geom_cfg_type           geom_cfg,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [15:0] depth
   input  logic                   req_tuser,   // start_of_frame
   input  logic                   q_full,
   output logic                   push,
   output grid_item_type          push_item
);

   logic [POS_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [POS_W-1:0]  gx_ff, gx_in, gy_ff, gy_in;
   logic [STEP_W-1:0] col_ph_ff, col_ph_in, row_ph_ff, row_ph_in;

   logic [POS_W-1:0]  cur_col, cur_row, cur_gx, cur_gy;
   logic [STEP_W-1:0] cur_col_ph, cur_row_ph;
   logic [SIZE_W-1:0] col_ext, row_ext, step_ext;
   logic [STEP_W:0]   col_ph_inc, row_ph_inc;
   logic              accept, grid;

   always_comb begin
      req_tready = !q_full;
      accept     = req_tvalid && !q_full;

      // start of frame forces position (0,0)
      cur_col    = req_tuser ? '0 : col_ff;
      cur_row    = req_tuser ? '0 : row_ff;
      cur_gx     = req_tuser ? '0 : gx_ff;
      cur_gy     = req_tuser ? '0 : gy_ff;
      cur_col_ph = req_tuser ? '0 : col_ph_ff;
      cur_row_ph = req_tuser ? '0 : row_ph_ff;

      col_ext  = {1'b0, cur_col};
      row_ext  = {1'b0, cur_row};
      step_ext = SIZE_W'(geom_cfg.grid_step);

      // classify: on the grid and inside the frame
      grid = (cur_col_ph == '0) && (cur_row_ph == '0) &&
             (col_ext < geom_cfg.frame_width) && (row_ext < geom_cfg.frame_height);

      push                = accept && grid;
      push_item.depth     = req_tdata[DEPTH_W-1:0];
      push_item.grid_col  = cur_gx;
      push_item.cell_row  = cur_gy - POS_W'(2);
      push_item.cell_col  = cur_gx - POS_W'(2);
      push_item.emit      = (cur_gx >= POS_W'(2)) && (cur_gy >= POS_W'(2));
      // last grid column and row: the next grid point would fall outside
      push_item.last      = ((col_ext + step_ext) >= geom_cfg.frame_width) &&
                            ((row_ext + step_ext) >= geom_cfg.frame_height);

      // position advance
      col_ph_inc = {1'b0, cur_col_ph} + 1'b1;
      row_ph_inc = {1'b0, cur_row_ph} + 1'b1;
      col_in     = cur_col;
      row_in     = cur_row;
      gx_in      = cur_gx;
      gy_in      = cur_gy;
      col_ph_in  = cur_col_ph;
      row_ph_in  = cur_row_ph;
      if ((col_ext + 1'b1) >= geom_cfg.frame_width) begin
         col_in    = '0;
         col_ph_in = '0;
         gx_in     = '0;
         if ((row_ext + 1'b1) >= geom_cfg.frame_height) begin
            row_in    = '0;
            row_ph_in = '0;
            gy_in     = '0;
         end else begin
            row_in = cur_row + 1'b1;
            if (row_ph_inc >= {1'b0, geom_cfg.grid_step}) begin
               row_ph_in = '0;
               gy_in     = cur_gy + 1'b1;
            end else begin
               row_ph_in = row_ph_inc[STEP_W-1:0];
            end
         end
      end else begin
         col_in = cur_col + 1'b1;
         if (col_ph_inc >= {1'b0, geom_cfg.grid_step}) begin
            col_ph_in = '0;
            gx_in     = cur_gx + 1'b1;
         end else begin
            col_ph_in = col_ph_inc[STEP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         gx_ff     <= '0;
         gy_ff     <= '0;
         col_ph_ff <= '0;
         row_ph_ff <= '0;
      end else if (accept) begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         gx_ff     <= gx_in;
         gy_ff     <= gy_in;
         col_ph_ff <= col_ph_in;
         row_ph_ff <= row_ph_in;
      end
   end

endmodule

// ===== hdl/ddm_queue.sv =====
// Short FIFO of grid points between the front end and the back end.
// Depends on ddm_pkg.
module ddm_queue import ddm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  grid_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output grid_item_type head_item
);

   grid_item_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/ddm_back.sv =====
// Back end: line store lookup, 3x3 window shift, threshold product and the
// neighbour checks, with the result register on the rsp side.
// Depends on ddm_pkg and ddm_ram.
module ddm_back import ddm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  check_cfg_type          check_cfg,
   input  logic                   q_valid,
   input  grid_item_type          q_item,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [11:0] cell_row, [23:12] cell_col,
                                                // [24] consistent, rest zero
   output logic                   rsp_tlast    // last
);

   logic                adv;
   logic [PAIR_W-1:0]   rd_data, pair;
   logic [DEPTH_W-1:0]  up, mid;
   logic                fwd;

   // lookup stage
   logic                b_valid_ff;
   grid_item_type       b_item_ff;

   // last line store write, for read-after-write forwarding
   logic                lw_valid_ff;
   logic [GRID_AW-1:0]  lw_addr_ff;
   logic [PAIR_W-1:0]   lw_data_ff;

   // window and check stage
   logic [DEPTH_W-1:0]  win_ff [WIN_N];
   logic [DEPTH_W-1:0]  win_in [WIN_N];
   logic [THR_W-1:0]    thr_ff, thr_in;
   logic                c_valid_ff, c_emit_ff, c_last_ff;
   logic [POS_W-1:0]    c_row_ff, c_col_ff;
   logic                ok;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]    rsp_row_ff, rsp_col_ff;
   logic                rsp_ok_ff, rsp_last_ff;

   // the whole back pipeline moves together when the result slot can take a word
   assign adv   = !rsp_valid_ff || rsp_tready;
   assign q_pop = adv && q_valid;

   ddm_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (GRID_COLS)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (adv && b_valid_ff),
      .wr_addr (b_item_ff.grid_col),
      .wr_data ({mid, b_item_ff.depth}),
      .rd_en   (q_pop),
      .rd_addr (q_item.grid_col),
      .rd_data (rd_data)
   );

   // line store data: upper row in the high half, middle row in the low half
   always_comb begin
      fwd  = lw_valid_ff && (lw_addr_ff == b_item_ff.grid_col);
      pair = fwd ? lw_data_ff : rd_data;
      up   = pair[PAIR_W-1:DEPTH_W];
      mid  = pair[DEPTH_W-1:0];
   end

   // window shift: two left columns take the old right ones, new column on the right
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]     = win_ff[r*3 + 1];
         win_in[r*3 + 1] = win_ff[r*3 + 2];
      end
      win_in[2] = up;
      win_in[5] = mid;
      win_in[8] = b_item_ff.depth;
      // new centre is the old middle-right sample
      thr_in = {{DEPTH_W{1'b0}}, check_cfg.rel_step} * {{RS_W{1'b0}}, win_ff[5]};
   end

   // centre range and neighbour checks
   always_comb begin
      logic [DEPTH_W-1:0] centre;
      logic [DEPTH_W-1:0] diff;
      centre = win_ff[WIN_CENTRE];
      ok = (centre >= check_cfg.depth_lo) && (centre <= check_cfg.depth_hi);
      for (int k = 0; k < WIN_N; k++) begin
         diff = (win_ff[k] > centre) ? (win_ff[k] - centre) : (centre - win_ff[k]);
         if ((k != WIN_CENTRE) && (win_ff[k] != '0) &&
             (THR_W'({diff, {FRAC_W{1'b0}}}) >= thr_ff)) begin
            ok = 1'b0;
         end
      end
   end

   assign rsp_valid_in = c_valid_ff && c_emit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         lw_valid_ff  <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WIN_N; i++) begin
            win_ff[i] <= '0;
         end
      end else if (adv) begin
         b_valid_ff   <= q_valid;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (b_valid_ff) begin
            lw_valid_ff <= 1'b1;
            for (int i = 0; i < WIN_N; i++) begin
               win_ff[i] <= win_in[i];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         if (q_valid) begin
            b_item_ff <= q_item;
         end
         if (b_valid_ff) begin
            lw_addr_ff <= b_item_ff.grid_col;
            lw_data_ff <= {mid, b_item_ff.depth};
            thr_ff     <= thr_in;
            c_emit_ff  <= b_item_ff.emit;
            c_last_ff  <= b_item_ff.last;
            c_row_ff   <= b_item_ff.cell_row;
            c_col_ff   <= b_item_ff.cell_col;
         end
         if (rsp_valid_in) begin
            rsp_row_ff  <= c_row_ff;
            rsp_col_ff  <= c_col_ff;
            rsp_ok_ff   <= ok;
            rsp_last_ff <= c_last_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ok_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/depth_discontinuity_mask.sv =====
// Depth discontinuity mask: takes a depth image one pixel word per clock in
// raster order (start_of_frame on tuser) and returns one cell word for every
// interior grid point, flagging it consistent or rejected; border cells are
// not sent. The front end accepts one pixel per clock while its four-word
// grid point queue has room, and the back end retires one grid point per
// clock unless rsp back pressure holds it, a rate set by the line store
// RAM's single read and single write port. A cell word passes the queue
// and the lookup, check and result registers. Back pressure on rsp stalls
// req only once the queue is full. The line store needs no clearing after reset.
// Depends on ddm_pkg, ddm_front, ddm_queue, ddm_back and ddm_ram.
module depth_discontinuity_mask import ddm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_we,
   input  logic [CSR_AW-1:0]      csr_addr,
   input  logic [CSR_DW-1:0]      csr_wdata,
   // pixel stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [15:0] depth
   input  logic                   req_tuser,   // start_of_frame
   // cell stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [11:0] cell_row, [23:12] cell_col,
                                                // [24] consistent, rest zero
   output logic                   rsp_tlast    // last
);

   logic [SIZE_W-1:0]  frame_width_ff, frame_height_ff, size_in;
   logic [STEP_W-1:0]  grid_step_ff, step_in;
   logic [REL_W-1:0]   rel_threshold_ff;
   logic [DEPTH_W-1:0] depth_lo_ff, depth_hi_ff;
   logic [RS_W-1:0]    rel_step_ff;

   geom_cfg_type  geom_cfg;
   check_cfg_type check_cfg;

   logic          push, q_full, q_pop, q_valid;
   grid_item_type push_item, q_item;

   // frame sizes clamp to 1..4096, grid step zero acts as one
   always_comb begin
      size_in = csr_wdata[SIZE_W-1:0];
      if (size_in == '0) begin
         size_in = SIZE_W'(1);
      end else if (size_in > SIZE_W'(SIZE_MAX)) begin
         size_in = SIZE_W'(SIZE_MAX);
      end
      step_in = csr_wdata[STEP_W-1:0];
      if (step_in == '0) begin
         step_in = STEP_W'(1);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= SIZE_W'(640);
         frame_height_ff  <= SIZE_W'(480);
         grid_step_ff     <= STEP_W'(1);
         rel_threshold_ff <= REL_W'(655);
         depth_lo_ff      <= DEPTH_W'(400);
         depth_hi_ff      <= DEPTH_W'(3000);
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_FRAME_WIDTH:   frame_width_ff   <= size_in;
            CSR_FRAME_HEIGHT:  frame_height_ff  <= size_in;
            CSR_GRID_STEP:     grid_step_ff     <= step_in;
            CSR_REL_THRESHOLD: rel_threshold_ff <= csr_wdata[REL_W-1:0];
            CSR_DEPTH_LO:      depth_lo_ff      <= csr_wdata[DEPTH_W-1:0];
            CSR_DEPTH_HI:      depth_hi_ff      <= csr_wdata[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   // threshold scaled by grid step, kept ready for the back end
   always_ff @(posedge clock) begin
      rel_step_ff <= {{STEP_W{1'b0}}, rel_threshold_ff} * {{REL_W{1'b0}}, grid_step_ff};
   end

   assign geom_cfg.frame_width   = frame_width_ff;
   assign geom_cfg.frame_height  = frame_height_ff;
   assign geom_cfg.grid_step     = grid_step_ff;
   assign check_cfg.rel_step     = rel_step_ff;
   assign check_cfg.depth_lo     = depth_lo_ff;
   assign check_cfg.depth_hi     = depth_hi_ff;

   ddm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .geom_cfg   (geom_cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   ddm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (q_item)
   );

   ddm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .check_cfg  (check_cfg),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== bench/depth_discontinuity_mask_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for depth_discontinuity_mask: streams depth frames on req, predicts
// the flag of every interior grid cell and checks each rsp word against it in order.
// Depends on ddm_pkg and the depth_discontinuity_mask top level.
module depth_discontinuity_mask_tb import ddm_pkg::*;;

   localparam int CLK_HALF       = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int WATCHDOG_LIMIT = 4000;   // well above the long hold and the longest gaps
   localparam int DRAIN_CYCLES   = 8;      // cell word trails its pixel through the queue and back end registers
   localparam int RANDOM_PIXELS  = 320;
   localparam int LONG_HOLD      = 400;

   // one expected cell word
   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             kept;
      logic             frame_end;
   } mask_flag_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_AW-1:0]      csr_addr;
   logic [CSR_DW-1:0]      csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   // register mirror, reset values
   logic [SIZE_W-1:0]  cfg_width  = 13'd640;
   logic [SIZE_W-1:0]  cfg_height = 13'd480;
   logic [STEP_W-1:0]  cfg_step   = 4'd1;
   logic [REL_W-1:0]   cfg_rel    = 16'd655;
   logic [DEPTH_W-1:0] cfg_min    = 16'd400;
   logic [DEPTH_W-1:0] cfg_max    = 16'd3000;

   // predicted block state
   logic [DEPTH_W-1:0] line_upper  [GRID_COLS];
   logic [DEPTH_W-1:0] line_middle [GRID_COLS];
   logic [DEPTH_W-1:0] win [WIN_N];
   int unsigned        pos_col = 0;
   int unsigned        pos_row = 0;

   mask_flag_type cells_due [$];
   int unsigned mismatches    = 0;
   int unsigned pixels_sent   = 0;
   int unsigned frames_sent   = 0;
   int unsigned settings_done = 0;
   int unsigned cells_checked = 0;
   int unsigned cells_kept    = 0;
   int unsigned idle_cycles   = 0;
   int unsigned hold_len      = 0;
   bit          no_gaps       = 1'b0;

   depth_discontinuity_mask i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // frame sizes of 0 act as 1, anything above the maximum as the maximum
   function automatic int unsigned eff_size(logic [SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > SIZE_MAX) return SIZE_MAX;
      return 32'(v);
   endfunction

   // mostly no gap, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // smooth surface around base, with holes, saturated spikes and the odd wild value
   function automatic logic [DEPTH_W-1:0] pick_depth(int unsigned base, int unsigned jitter,
                                                     bit wild);
      int unsigned r;
      int          v;
      r = $urandom_range(0, 99);
      if (wild || r < 4) return DEPTH_W'($urandom_range(0, 65535));
      if (r < 9) return '0;
      if (r < 11) return '1;
      v = int'(base) - int'(jitter) + int'($urandom_range(0, 2 * jitter));
      return DEPTH_W'(v);
   endfunction

   // mismatch report
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR at %0t ns: %s is %0d, predicted %0d", $time, what, got, want);
      mismatches++;
   endtask

   // advance the predicted position, line stores and window by one accepted pixel
   task automatic predict_cell_flag(input logic [DEPTH_W-1:0] d, input logic sof);
      int unsigned        w, h, s, col, row, gx, gy;
      logic [DEPTH_W-1:0] up, mid, c, nb;
      logic [63:0]        thr, diff;
      logic               ok;
      mask_flag_type      flag;
      w = eff_size(cfg_width);
      h = eff_size(cfg_height);
      s = (cfg_step == 0) ? 1 : 32'(cfg_step);
      if (sof) begin
         pos_col = 0;
         pos_row = 0;
      end
      col = pos_col;
      row = pos_row;
      if (col % s == 0 && row % s == 0 && col < w && row < h) begin
         gx = col / s;
         gy = row / s;
         up = '0;
         mid = '0;
         if (gx < GRID_COLS) begin
            up = line_upper[gx];
            mid = line_middle[gx];
            line_upper[gx] = mid;
            line_middle[gx] = d;
         end
         for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
         end
         win[2] = up;
         win[5] = mid;
         win[8] = d;
         // centre is complete once its lower-right neighbour has arrived
         if (gx >= 2 && gy >= 2) begin
            c = win[WIN_CENTRE];
            thr = 64'(cfg_rel) * 64'(s) * 64'(c);
            ok = !(c < cfg_min || c > cfg_max);
            for (int k = 0; k < WIN_N; k++) begin
               nb = win[k];
               if (k != WIN_CENTRE && nb != 0) begin
                  diff = (nb > c) ? 64'(nb - c) : 64'(c - nb);
                  if ((diff << FRAC_W) >= thr) ok = 1'b0;
               end
            end
            flag.row = POS_W'(gy - 2);
            flag.col = POS_W'(gx - 2);
            flag.kept = ok;
            flag.frame_end = (gx == (w - 1) / s && gy == (h - 1) / s);
            cells_due.push_back(flag);
         end
      end
      if (col + 1 >= w) begin
         pos_col = 0;
         pos_row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         pos_col = col + 1;
      end
   endtask

   // offer one pixel word and wait for it to be taken
   task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic sof);
      int unsigned gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= depth;
      req_tuser <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_cell_flag(depth, sof);
      pixels_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_frame(input bit with_sof, input bit wild, input int unsigned count);
      int unsigned base, jitter;
      base = $urandom_range(200, 5000);
      jitter = $urandom_range(0, base / 40 + 1);
      for (int unsigned i = 0; i < count; i++)
         send_pixel(pick_depth(base, jitter, wild), with_sof && i == 0);
      frames_sent++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_FRAME_WIDTH:   cfg_width  = value[SIZE_W-1:0];
         CSR_FRAME_HEIGHT:  cfg_height = value[SIZE_W-1:0];
         CSR_GRID_STEP:     cfg_step   = value[STEP_W-1:0];
         CSR_REL_THRESHOLD: cfg_rel    = value[REL_W-1:0];
         CSR_DEPTH_LO:      cfg_min    = value[DEPTH_W-1:0];
         CSR_DEPTH_HI:      cfg_max    = value[DEPTH_W-1:0];
         default: ;
      endcase
   endtask

   // stop offering, let every predicted word arrive, then allow for pixels still in flight
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (cells_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input int unsigned w, input int unsigned h,
                                 input int unsigned s, input int unsigned rel,
                                 input int unsigned lo, input int unsigned hi);
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, CSR_DW'(w));
      write_reg(CSR_FRAME_HEIGHT, CSR_DW'(h));
      write_reg(CSR_GRID_STEP, CSR_DW'(s));
      write_reg(CSR_REL_THRESHOLD, CSR_DW'(rel));
      write_reg(CSR_DEPTH_LO, CSR_DW'(lo));
      write_reg(CSR_DEPTH_HI, CSR_DW'(hi));
      @(negedge clock);
      csr_we <= 1'b0;
      settings_done++;
   endtask

   // hand-built 3x3 frames: zero centre, thresholds at the exact boundary, row wrap
   task automatic test_directed();
      logic [DEPTH_W-1:0] px [WIN_N];
      // zero centre: the zero neighbours are skipped, the full-scale corner rejects
      apply_settings(3, 3, 1, 655, 0, 16'hFFFF);
      px = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF};
      for (int i = 0; i < WIN_N; i++) send_pixel(px[i], i == 0);
      // half threshold, centre pinned at min = max; neighbours one below the limit
      apply_settings(3, 3, 1, 32768, 1000, 1000);
      px = '{16'd1499, 16'd501, 16'd0, 16'd1000, 16'd1000, 16'd1499, 16'd501, 16'd1499,
             16'd501};
      for (int i = 0; i < WIN_N; i++) send_pixel(px[i], i == 0);
      // neighbour exactly on the threshold rejects; no start flag, position has wrapped
      px = '{16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000,
             16'd1000, 16'd1500};
      for (int i = 0; i < WIN_N; i++) send_pixel(px[i], 1'b0);
      frames_sent += 3;
   endtask

   // random settings, each followed by a few frames, some wrapped, some cut short
   task automatic test_random_frames();
      int unsigned target, r, s, se, w, h, rel, lo, hi, full, nframes;
      bit          need_sof, wild;
      target = pixels_sent + RANDOM_PIXELS;
      while (pixels_sent < target) begin
         r = $urandom_range(0, 9);
         s = (r == 0) ? 0 : (r < 5) ? 1 : (r < 8) ? 2 : $urandom_range(3, 4);
         se = (s == 0) ? 1 : s;
         w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1)
                                          : $urandom_range(2 * se + 1, 2 * se + 9);
         h = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1)
                                          : $urandom_range(2 * se + 1, 2 * se + 7);
         r = $urandom_range(0, 9);
         rel = (r == 0) ? 0 : (r == 1) ? 65535 : (r < 6) ? $urandom_range(200, 3000)
                                                         : $urandom_range(0, 65535);
         r = $urandom_range(0, 9);
         if (r < 7) begin
            lo = $urandom_range(0, 800);
            hi = $urandom_range(1500, 65535);
         end else if (r == 7) begin
            lo = 0;
            hi = 65535;
         end else if (r == 8) begin
            lo = $urandom_range(0, 65535);
            hi = $urandom_range(0, 65535);
         end else begin
            lo = $urandom_range(0, 6000);
            hi = lo;
         end
         apply_settings(w, h, s, rel, lo, hi);
         no_gaps = ($urandom_range(0, 4) == 0);
         need_sof = 1'b1;
         full = eff_size(w) * eff_size(h);
         nframes = $urandom_range(1, 4);
         for (int f = 0; f < nframes; f++) begin
            r = $urandom_range(0, 99);
            wild = ($urandom_range(0, 9) == 0);
            if (r < 15) begin
               // cut short, the next frame restarts with a start flag
               send_frame(1'b1, wild, $urandom_range(1, full));
               need_sof = 1'b1;
            end else if (r < 25 && !need_sof) begin
               send_frame(1'b0, wild, full);
            end else begin
               send_frame(1'b1, wild, full);
               need_sof = 1'b0;
            end
         end
         no_gaps = 1'b0;
      end
   endtask

   // receiver stops for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      apply_settings(10, 8, 1, 655, 0, 65535);
      no_gaps = 1'b1;
      hold_len = LONG_HOLD;
      send_frame(1'b1, 1'b0, 80);
      while (hold_len != 0) @(posedge clock);
      no_gaps = 1'b0;
   endtask

   // a large step of 8, and step zero
   task automatic test_large_steps();
      apply_settings(17, 17, 8, 655, 0, 65535);
      send_frame(1'b1, 1'b0, 17 * 17);
      apply_settings(5, 5, 0, 655, 100, 60000);
      send_frame(1'b1, 1'b0, 25);
   endtask

   // sizes beyond the limits: zero width, an oversized width cut short, an oversized height
   task automatic test_size_clamp();
      apply_settings(0, 5, 1, 655, 0, 65535);
      send_frame(1'b1, 1'b0, 5);
      apply_settings(8191, 3, 1, 655, 0, 65535);
      send_frame(1'b1, 1'b0, 40);
      apply_settings(3, 8191, 1, 1000, 300, 5000);
      send_frame(1'b1, 1'b0, 3 * 12);
   endtask

   // receiver: random stalls, plus the long hold counted down here
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_len != 0) begin
            rsp_tready <= 1'b0;
            hold_len--;
         end else if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // compare each accepted cell word with the oldest prediction
   always @(posedge clock) begin
      mask_flag_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cells_due.size() == 0) begin
            report_mismatch("unexpected cell word, row", int'(rsp_tdata[POS_W-1:0]), -1);
         end else begin
            want = cells_due.pop_front();
            cells_checked++;
            if (want.kept) cells_kept++;
            if (rsp_tdata[POS_W-1:0] != want.row)
               report_mismatch("cell_row", int'(rsp_tdata[POS_W-1:0]), int'(want.row));
            if (rsp_tdata[2*POS_W-1:POS_W] != want.col)
               report_mismatch("cell_col", int'(rsp_tdata[2*POS_W-1:POS_W]),
                               int'(want.col));
            if (rsp_tdata[2*POS_W] != want.kept)
               report_mismatch("consistent", int'(rsp_tdata[2*POS_W]), int'(want.kept));
            if (rsp_tdata[RSP_TDATA_W-1:RSP_FIELD_W] != '0)
               report_mismatch("tdata padding",
                               int'(rsp_tdata[RSP_TDATA_W-1:RSP_FIELD_W]), 0);
            if (rsp_tlast != want.frame_end)
               report_mismatch("last", int'(rsp_tlast), int'(want.frame_end));
         end
      end
   end

   // watchdog: cycles with no word moving on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // test sequence
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_addr = CSR_FRAME_WIDTH;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      foreach (line_upper[i]) begin
         line_upper[i] = '0;
         line_middle[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_frames();
      test_backpressure();
      test_large_steps();
      test_size_clamp();
      wait_idle();

      $display("Ran %0d frames, %0d pixel words over %0d settings (steps 0 to 8, clamped sizes)",
               frames_sent, pixels_sent, settings_done);
      $display("Checked %0d cell words: %0d consistent, %0d rejected, %0d mismatches",
               cells_checked, cells_kept, cells_checked - cells_kept, mismatches);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== depth_discontinuity_mask.f =====
hdl/ddm_pkg.sv
hdl/ddm_ram.sv
hdl/ddm_front.sv
hdl/ddm_queue.sv
hdl/ddm_back.sv
hdl/depth_discontinuity_mask.sv
bench/depth_discontinuity_mask_tb.sv
